/* rtl/ascon_pkg.sv */
// ascon-128 aead core package: sequencer and phase types, register indexes,
// round function, byte mask and padding helpers. no dependencies.
`timescale 1ns / 1ps

package ascon_pkg;

    localparam int unsigned WordW    = 64;
    localparam int unsigned NumWords = 5;
    localparam logic [WordW-1:0] AsconIv = 64'h80400c0600000000;

    // config register indexes
    localparam logic [0:0] RegKeyUpper = 1'b0;
    localparam logic [0:0] RegKeyLower = 1'b1;

    typedef logic [NumWords-1:0][WordW-1:0] t_sponge;
    typedef logic [WordW-1:0] t_word;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_AD      = 2'd1,
        MODE_PAYLOAD = 2'd2,
        MODE_FINISH  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_AD_EMPTY = 3'd1,
        PH_AD_OPEN  = 3'd2,
        PH_PT_OPEN  = 3'd3,
        PH_PT_DONE  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_PERM = 3'd1,
        ST_POST = 3'd2,
        ST_DATA = 3'd3,
        ST_FIN  = 3'd4,
        ST_OUT  = 3'd5
    } t_seq;

    // what to do after the permutation ends
    typedef enum logic [2:0] {
        FIN_START   = 3'd0,
        FIN_AD_FULL = 3'd1,
        FIN_AD_LAST = 3'd2,
        FIN_CLOSE   = 3'd3,
        FIN_DATA    = 3'd4,
        FIN_TAG     = 3'd5
    } t_fin;

    localparam logic [3:0] LastRound  = 4'd11;
    localparam logic [3:0] FirstP12   = 4'd0;
    localparam logic [3:0] FirstP6    = 4'd6;
    localparam logic [3:0] FullBlock  = 4'd8;

    function automatic logic [7:0] round_const(input logic [3:0] rnd);
        logic [7:0] c;
        case (rnd)
            4'd0:    c = 8'hf0;
            4'd1:    c = 8'he1;
            4'd2:    c = 8'hd2;
            4'd3:    c = 8'hc3;
            4'd4:    c = 8'hb4;
            4'd5:    c = 8'ha5;
            4'd6:    c = 8'h96;
            4'd7:    c = 8'h87;
            4'd8:    c = 8'h78;
            4'd9:    c = 8'h69;
            4'd10:   c = 8'h5a;
            4'd11:   c = 8'h4b;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_word rotr(input t_word v, input int unsigned n);
        return (v >> n) | (v << (WordW - n));
    endfunction

    function automatic t_sponge ascon_round(input t_sponge xi, input logic [3:0] rnd);
        t_sponge x;
        t_word   t0, t1, t2, t3, t4;
        x = xi;
        // constant addition and substitution layer
        x[2] = x[2] ^ {56'd0, round_const(rnd)};
        x[0] = x[0] ^ x[4];
        x[4] = x[4] ^ x[3];
        x[2] = x[2] ^ x[1];
        t0 = ~x[0] & x[1];
        t1 = ~x[1] & x[2];
        t2 = ~x[2] & x[3];
        t3 = ~x[3] & x[4];
        t4 = ~x[4] & x[0];
        x[0] = x[0] ^ t1;
        x[1] = x[1] ^ t2;
        x[2] = x[2] ^ t3;
        x[3] = x[3] ^ t4;
        x[4] = x[4] ^ t0;
        x[1] = x[1] ^ x[0];
        x[0] = x[0] ^ x[4];
        x[3] = x[3] ^ x[2];
        x[2] = ~x[2];
        // linear diffusion layer
        x[0] = x[0] ^ rotr(x[0], 19) ^ rotr(x[0], 28);
        x[1] = x[1] ^ rotr(x[1], 61) ^ rotr(x[1], 39);
        x[2] = x[2] ^ rotr(x[2], 1)  ^ rotr(x[2], 6);
        x[3] = x[3] ^ rotr(x[3], 10) ^ rotr(x[3], 17);
        x[4] = x[4] ^ rotr(x[4], 7)  ^ rotr(x[4], 41);
        return x;
    endfunction

    // leading valid bytes, first byte in the top bits
    function automatic t_word byte_mask(input logic [3:0] v);
        t_word m;
        case (v)
            4'd0:    m = 64'h0000000000000000;
            4'd1:    m = 64'hff00000000000000;
            4'd2:    m = 64'hffff000000000000;
            4'd3:    m = 64'hffffff0000000000;
            4'd4:    m = 64'hffffffff00000000;
            4'd5:    m = 64'hffffffffff000000;
            4'd6:    m = 64'hffffffffffff0000;
            4'd7:    m = 64'hffffffffffffff00;
            default: m = 64'hffffffffffffffff;
        endcase
        return m;
    endfunction

    // 0x80 right after the last valid byte
    function automatic t_word pad_word(input logic [3:0] v);
        t_word p;
        case (v)
            4'd0:    p = 64'h8000000000000000;
            4'd1:    p = 64'h0080000000000000;
            4'd2:    p = 64'h0000800000000000;
            4'd3:    p = 64'h0000008000000000;
            4'd4:    p = 64'h0000000080000000;
            4'd5:    p = 64'h0000000000800000;
            4'd6:    p = 64'h0000000000008000;
            4'd7:    p = 64'h0000000000000080;
            default: p = 64'h0000000000000000;
        endcase
        return p;
    endfunction

endpackage

/* rtl/ascon128_aead_core_top.sv */
// ascon-128 aead core: sponge state, phase tracking and one shared round unit
// under a small sequencer. depends on ascon_pkg.
`timescale 1ns / 1ps

// usage
// - config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   key_upper (index 0) and key_lower (index 1); write only while idle
// - input stream s_axis_*: tuser carries mode and decrypt, tdata the nonce,
//   data block, expected tag and byte count
// - output stream m_axis_*: exactly one result item for every input item
// - the single round unit does one permutation round per cycle
// - start: 12 rounds, then the key step and the result item
// - associated data block: 6 rounds; full payload block: 6 rounds;
//   partial payload block: no rounds; closing open associated data first
//   adds 6 rounds
// - finish: 12 rounds (plus 6 when it also closes associated data)
// - out of sequence items and empty associated data go straight to output;
//   the next input item can be accepted in the cycle after the result is taken
// - one item at a time: s_axis_tready is low from acceptance until the
//   result item has been taken, so a stalled receiver holds the result
//   and blocks the next input item
// - synchronous reset clears the key, phase and direction; the block then
//   expects a start item

module ascon128_aead_core_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: block_upper[63:0], block_lower[127:64], valid_bytes[131:128], zero
    input  logic [135:0] s_axis_tdata,
    // tuser: mode[1:0], decrypt[2]
    input  logic [2:0]   s_axis_tuser,
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: data_out[63:0], data_bytes[67:64], tag_upper[131:68],
    //        tag_lower[195:132], zero
    output logic [199:0] m_axis_tdata,
    // tuser: tag_match[0], status[1]
    output logic [1:0]   m_axis_tuser
);
    import ascon_pkg::*;

    t_seq    r_st, n_st;
    t_phase  r_phase, n_phase;
    t_fin    r_fin, n_fin;
    t_sponge r_x, n_x;
    logic [3:0] r_rnd, n_rnd;
    logic    r_dir, n_dir;
    t_word   r_key_up, r_key_lo;
    t_mode   r_mode, n_mode;
    t_word   r_bu, n_bu, r_bl, n_bl;
    logic [3:0] r_vb, n_vb;
    t_word   r_dout, n_dout;
    logic [3:0] r_dbytes, n_dbytes;
    t_word   r_tagu, n_tagu, r_tagl, n_tagl;
    logic    r_match, n_match, r_status, n_status;

    logic    in_acc;
    t_mode   in_mode;
    t_word   in_bu, in_bl;
    logic [3:0] in_vb;
    logic    in_bad;
    t_word   mask_v, tag_u, tag_l;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_st == ST_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign in_mode       = t_mode'(s_axis_tuser[1:0]);
    assign in_bu         = s_axis_tdata[63:0];
    assign in_bl         = s_axis_tdata[127:64];
    // counts above a full block act as a full block
    assign in_vb         = (s_axis_tdata[131:128] > FullBlock) ? FullBlock
                                                               : s_axis_tdata[131:128];

    always_comb begin
        case (in_mode)
            MODE_START:   in_bad = 1'b0;
            MODE_AD:      in_bad = !(r_phase == PH_AD_EMPTY || r_phase == PH_AD_OPEN);
            MODE_PAYLOAD: in_bad = (r_phase == PH_IDLE) || (r_phase == PH_PT_DONE);
            default:      in_bad = (r_phase == PH_IDLE);
        endcase
    end

    assign mask_v = byte_mask(r_vb);
    assign tag_u  = r_x[3] ^ r_key_up;
    assign tag_l  = r_x[4] ^ r_key_lo;

    assign m_axis_tvalid = (r_st == ST_OUT);
    assign m_axis_tdata  = {4'd0, r_tagl, r_tagu, r_dbytes, r_dout};
    assign m_axis_tuser  = {r_status, r_match};

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_bad) begin
                        n_st = ST_OUT;
                    end else begin
                        unique case (in_mode)
                            MODE_START: n_st = ST_PERM;
                            MODE_AD: begin
                                if (in_vb == 4'd0 && r_phase == PH_AD_EMPTY) begin
                                    n_st = ST_OUT;
                                end else begin
                                    n_st = ST_PERM;
                                end
                            end
                            MODE_PAYLOAD: begin
                                n_st = (r_phase == PH_AD_OPEN) ? ST_PERM : ST_DATA;
                            end
                            MODE_FINISH: begin
                                n_st = (r_phase == PH_AD_OPEN) ? ST_PERM : ST_FIN;
                            end
                        endcase
                    end
                end
            end
            ST_PERM: begin
                if (r_rnd == LastRound) begin
                    n_st = ST_POST;
                end
            end
            ST_POST: begin
                if (r_fin == FIN_CLOSE) begin
                    n_st = (r_mode == MODE_PAYLOAD) ? ST_DATA : ST_FIN;
                end else begin
                    n_st = ST_OUT;
                end
            end
            ST_DATA: n_st = (r_vb == FullBlock) ? ST_PERM : ST_OUT;
            ST_FIN:  n_st = ST_PERM;
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_x      = r_x;
        n_phase  = r_phase;
        n_fin    = r_fin;
        n_rnd    = r_rnd;
        n_dir    = r_dir;
        n_mode   = r_mode;
        n_bu     = r_bu;
        n_bl     = r_bl;
        n_vb     = r_vb;
        n_dout   = r_dout;
        n_dbytes = r_dbytes;
        n_tagu   = r_tagu;
        n_tagl   = r_tagl;
        n_match  = r_match;
        n_status = r_status;
        unique case (r_st)
            ST_IDLE: begin
                if (in_acc) begin
                    n_mode   = in_mode;
                    n_bu     = in_bu;
                    n_bl     = in_bl;
                    n_vb     = in_vb;
                    n_dout   = '0;
                    n_dbytes = '0;
                    n_tagu   = '0;
                    n_tagl   = '0;
                    n_match  = 1'b0;
                    n_status = in_bad;
                    if (!in_bad) begin
                        unique case (in_mode) inside
                            MODE_START: begin
                                n_dir = s_axis_tuser[2];
                                n_x   = {in_bl, in_bu, r_key_lo, r_key_up, AsconIv};
                                n_rnd = FirstP12;
                                n_fin = FIN_START;
                            end
                            MODE_AD: begin
                                n_rnd = FirstP6;
                                if (in_vb == FullBlock) begin
                                    n_x[0] = r_x[0] ^ in_bl;
                                    n_fin  = FIN_AD_FULL;
                                end else if (in_vb == 4'd0 && r_phase == PH_AD_EMPTY) begin
                                    n_x[4]  = r_x[4] ^ 64'd1;
                                    n_phase = PH_PT_OPEN;
                                end else begin
                                    n_x[0] = r_x[0] ^ (in_bl & byte_mask(in_vb))
                                             ^ pad_word(in_vb);
                                    n_fin  = FIN_AD_LAST;
                                end
                            end
                            MODE_PAYLOAD, MODE_FINISH: begin
                                // close associated data first
                                if (r_phase == PH_AD_OPEN) begin
                                    n_x[0] = r_x[0] ^ pad_word(4'd0);
                                    n_rnd  = FirstP6;
                                    n_fin  = FIN_CLOSE;
                                end else if (r_phase == PH_AD_EMPTY) begin
                                    n_x[4]  = r_x[4] ^ 64'd1;
                                    n_phase = PH_PT_OPEN;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_PERM: begin
                n_x   = ascon_round(r_x, r_rnd);
                n_rnd = r_rnd + 4'd1;
            end
            ST_POST: begin
                case (r_fin) inside
                    FIN_START: begin
                        n_x[3]  = tag_u;
                        n_x[4]  = tag_l;
                        n_phase = PH_AD_EMPTY;
                    end
                    FIN_AD_FULL: n_phase = PH_AD_OPEN;
                    FIN_AD_LAST, FIN_CLOSE: begin
                        n_x[4]  = r_x[4] ^ 64'd1;
                        n_phase = PH_PT_OPEN;
                    end
                    FIN_TAG: begin
                        n_x[3]  = tag_u;
                        n_x[4]  = tag_l;
                        n_tagu  = tag_u;
                        n_tagl  = tag_l;
                        n_match = r_dir && (tag_u == r_bu) && (tag_l == r_bl);
                        n_phase = PH_IDLE;
                    end
                    default: ;
                endcase
            end
            ST_DATA: begin
                n_dbytes = r_vb;
                if (!r_dir) begin
                    n_x[0] = r_x[0] ^ (r_bl & mask_v);
                    n_dout = (r_x[0] ^ r_bl) & mask_v;
                end else begin
                    n_x[0] = (r_x[0] & ~mask_v) | (r_bl & mask_v);
                    n_dout = (r_x[0] ^ r_bl) & mask_v;
                end
                if (r_vb == FullBlock) begin
                    n_rnd = FirstP6;
                    n_fin = FIN_DATA;
                end else begin
                    n_x[0]  = n_x[0] ^ pad_word(r_vb);
                    n_phase = PH_PT_DONE;
                end
            end
            ST_FIN: begin
                // an open payload gets its lone padding byte
                if (r_phase == PH_PT_OPEN) begin
                    n_x[0] = r_x[0] ^ pad_word(4'd0);
                end
                n_x[1] = r_x[1] ^ r_key_up;
                n_x[2] = r_x[2] ^ r_key_lo;
                n_rnd  = FirstP12;
                n_fin  = FIN_TAG;
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_phase  <= PH_IDLE;
            r_dir    <= 1'b0;
            r_key_up <= '0;
            r_key_lo <= '0;
            r_fin    <= FIN_START;
            r_rnd    <= '0;
            r_mode   <= MODE_START;
        end else begin
            r_st    <= n_st;
            r_phase <= n_phase;
            r_dir   <= n_dir;
            r_fin   <= n_fin;
            r_rnd   <= n_rnd;
            r_mode  <= n_mode;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == RegKeyUpper) begin
                    r_key_up <= i_cfg_data;
                end else begin
                    r_key_lo <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_bu     <= n_bu;
        r_bl     <= n_bl;
        r_vb     <= n_vb;
        r_dout   <= n_dout;
        r_dbytes <= n_dbytes;
        r_tagu   <= n_tagu;
        r_tagl   <= n_tagl;
        r_match  <= n_match;
        r_status <= n_status;
    end

endmodule
